@@ design/l4ohb_pkg.sv @@
// Package for the L4 offload header builder: frame offsets, protocol codes
// and the packed layouts of the stream words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package l4ohb_pkg;

    // Stream word widths
    localparam int unsigned InDataW  = 32;
    localparam int unsigned OutDataW = 40;

    // Frame layout and protocol constants
    localparam logic [6:0]  PosEtherHi    = 7'd12;
    localparam logic [6:0]  PosEtherLo    = 7'd13;
    localparam logic [6:0]  PosIpVerLen   = 7'd14;
    localparam logic [6:0]  PosIpProto    = 7'd23;
    localparam logic [7:0]  TcpOffBase    = 8'd26;
    localparam logic [6:0]  CountMax      = 7'd127;
    localparam logic [7:0]  EthHdrBytes   = 8'd14;
    localparam logic [7:0]  MinFrameBytes = 8'd34;
    localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
    localparam logic [5:0]  MinIpHdrBytes = 6'd20;
    localparam logic [7:0]  ProtoTcp      = 8'd6;
    localparam logic [7:0]  ProtoUdp      = 8'd17;
    localparam logic [4:0]  TcpCsumOff    = 5'd16;
    localparam logic [4:0]  UdpCsumOff    = 5'd6;

    // Input word: data_byte, seg_request, seg_mss from bit 0 up
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] seg_mss;
        logic        seg_request;
        logic [7:0]  data_byte;
    } in_word_t;

    // Output word: seg_type, seg_size, headers_len, needs_csum,
    // cksum_begin, cksum_field_pos from bit 0 up
    typedef struct packed {
        logic [1:0]  pad;
        logic [4:0]  cksum_field_pos;
        logic [6:0]  cksum_begin;
        logic        needs_csum;
        logic [7:0]  headers_len;
        logic [15:0] seg_size;
        logic        seg_type;
    } out_word_t;

endpackage

`default_nettype wire

@@ design/l4_offload_header_builder.sv @@
// L4 offload header builder top level: parses a transmit frame byte stream
// and emits one offload header word per frame. Depends on l4ohb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one frame byte per cycle on the slave stream (tlast on the final
// byte) and, once the final byte has passed the input and output registers, presents one
// 40-bit offload header word on the master stream. Sustained rate is one
// byte per clock: an input register feeds the header capture and decision
// logic, which loads the output register; both stages advance whenever the
// output register is empty or being taken. Intermediate bytes produce no
// word. The checksum offload enable is written on the cfg channel; the user
// must write it only while no frame is in progress (the block does not enforce this).
module l4_offload_header_builder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // data_byte[7:0], seg_request[8], seg_mss[24:9], zero pad
    input  wire logic [l4ohb_pkg::InDataW-1:0]  s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // seg_type[0], seg_size[16:1], headers_len[24:17], needs_csum[25],
    // cksum_begin[32:26], cksum_field_pos[37:33], zero pad
    output logic [l4ohb_pkg::OutDataW-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // csum_offload_enable
    input  wire logic                            cfg_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready
);
    import l4ohb_pkg::*;

    logic        csum_en_reg;

    logic        in_valid_reg;
    logic        in_last_reg;
    in_word_t    in_word_reg;

    logic [6:0]  byte_count_reg;
    logic [15:0] ether_type_reg;
    logic [5:0]  ip_hdr_reg;
    logic [7:0]  ip_proto_reg;
    logic [5:0]  tcp_hdr_reg;

    logic        out_valid_reg;
    out_word_t   out_word_reg;

    logic        advance;
    logic        take;
    logic [6:0]  byte_count_next;
    logic [15:0] ether_type_next;
    logic [5:0]  ip_hdr_next;
    logic [7:0]  ip_proto_next;
    logic [5:0]  tcp_hdr_next;
    logic [7:0]  frame_bytes;
    logic        frame_ok;
    logic        is_tcp;
    logic        is_udp;
    out_word_t   out_word_next;

    assign advance   = !out_valid_reg || m_tready;
    assign take      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_word_reg;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            csum_en_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= in_word_t'(s_tdata);
            in_last_reg <= s_tlast;
        end
    end

    // Header field capture for the current byte
    always_comb
    begin
        ether_type_next = ether_type_reg;
        ip_hdr_next     = ip_hdr_reg;
        ip_proto_next   = ip_proto_reg;
        tcp_hdr_next    = tcp_hdr_reg;
        if (byte_count_reg == PosEtherHi)
        begin
            ether_type_next[15:8] = in_word_reg.data_byte;
        end
        else if (byte_count_reg == PosEtherLo)
        begin
            ether_type_next[7:0] = in_word_reg.data_byte;
        end
        else if (byte_count_reg == PosIpVerLen)
        begin
            ip_hdr_next = {in_word_reg.data_byte[3:0], 2'b00};
        end
        else if (byte_count_reg == PosIpProto)
        begin
            ip_proto_next = in_word_reg.data_byte;
        end
        // TCP data offset sits 12 bytes into the L4 header
        if (byte_count_reg > PosIpVerLen
            && {1'b0, byte_count_reg} == TcpOffBase + {2'b00, ip_hdr_reg})
        begin
            tcp_hdr_next = {in_word_reg.data_byte[7:4], 2'b00};
        end
        byte_count_next = (byte_count_reg < CountMax) ? byte_count_reg + 7'd1
                                                       : byte_count_reg;
    end

    // Offload decision on the last byte
    always_comb
    begin
        frame_bytes = {1'b0, byte_count_reg} + 8'd1;
        frame_ok  = frame_bytes >= MinFrameBytes
                    && ether_type_next == EtherTypeIpv4
                    && ip_hdr_next >= MinIpHdrBytes
                    && frame_bytes >= MinFrameBytes + {2'b00, ip_hdr_next};
        is_tcp    = ip_proto_next == ProtoTcp;
        is_udp    = ip_proto_next == ProtoUdp;
        out_word_next = '0;
        if (frame_ok)
        begin
            if (in_word_reg.seg_request && is_tcp)
            begin
                out_word_next.seg_type    = 1'b1;
                out_word_next.seg_size    = in_word_reg.seg_mss;
                out_word_next.headers_len = EthHdrBytes + {2'b00, ip_hdr_next}
                                            + {2'b00, tcp_hdr_next};
            end
            else if (csum_en_reg && (is_tcp || is_udp))
            begin
                out_word_next.needs_csum      = 1'b1;
                out_word_next.cksum_begin     = EthHdrBytes[6:0] + {1'b0, ip_hdr_next};
                out_word_next.cksum_field_pos = is_tcp ? TcpCsumOff : UdpCsumOff;
            end
        end
    end

    // Frame state: advances per byte, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            ether_type_reg <= '0;
            ip_hdr_reg     <= '0;
            ip_proto_reg   <= '0;
            tcp_hdr_reg    <= '0;
        end
        else if (take)
        begin
            if (in_last_reg)
            begin
                byte_count_reg <= '0;
                ether_type_reg <= '0;
                ip_hdr_reg     <= '0;
                ip_proto_reg   <= '0;
                tcp_hdr_reg    <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                ether_type_reg <= ether_type_next;
                ip_hdr_reg     <= ip_hdr_next;
                ip_proto_reg   <= ip_proto_next;
                tcp_hdr_reg    <= tcp_hdr_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= take && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_last_reg)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/l4_offload_header_builder_tb.sv @@
// Self-checking testbench for l4_offload_header_builder: streams transmit
// frames byte by byte and checks each offload header word against a predictor.
// Depends on l4ohb_pkg and the l4_offload_header_builder RTL.
`timescale 1ns / 1ps

module l4_offload_header_builder_tb;

    import l4ohb_pkg::*;

    localparam logic [7:0] MinL4HdrBytes = 8'd20;
    localparam int         RxHoldCycles  = 300;
    localparam int         MaxErrPrints  = 40;

    // One frame byte plus its sideband fields
    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic        seg_req;
        logic [15:0] mss;
    } frame_byte_t;

    // Offload header fields of one result word
    typedef struct {
        logic        seg_type;
        logic [15:0] seg_size;
        logic [7:0]  headers_len;
        logic        needs_csum;
        logic [6:0]  cksum_begin;
        logic [4:0]  cksum_field_pos;
    } offload_hdr_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                cfg_data  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;

    frame_byte_t  frame_byte_q[$];
    offload_hdr_t hdr_expect_q[$];
    int           err_count    = 0;
    int           rand_bytes   = 0;
    int           rand_frames  = 0;
    int           tx_gap_left  = 0;
    int           rx_stall_left = 0;
    int           rx_hold_seq  = 0;
    int           rx_hold_seen = 0;
    bit           tx_steady    = 1'b0;
    bit           rx_steady    = 1'b0;

    // Predictor copy of the parser state and the enable register
    logic        csum_en_model = 1'b0;
    logic [6:0]  frame_pos     = '0;
    logic [15:0] cap_ether     = '0;
    logic [5:0]  cap_ip_len    = '0;
    logic [7:0]  cap_proto     = '0;
    logic [5:0]  cap_tcp_len   = '0;

    l4_offload_header_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        if (err_count < MaxErrPrints)
            $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Queue one frame; header fields are placed unless raw is set
    task automatic add_frame(input int len, input logic [15:0] etype,
                             input logic [3:0] ihl, input logic [7:0] proto,
                             input logic [3:0] doff, input logic seg_req,
                             input logic [15:0] mss, input bit raw);
        frame_byte_t fb;
        for (int p = 0; p < len; p++)
        begin
            fb.data    = 8'($urandom);
            fb.last    = (p == len - 1);
            fb.seg_req = fb.last ? seg_req : 1'($urandom);
            fb.mss     = fb.last ? mss : 16'($urandom);
            if (!raw)
            begin
                if (p == 12)
                    fb.data = etype[15:8];
                else if (p == 13)
                    fb.data = etype[7:0];
                else if (p == 14)
                    fb.data = {4'h4, ihl};
                else if (p == 23)
                    fb.data = proto;
                if (p == 26 + 4 * int'(ihl))
                    fb.data[7:4] = doff;
            end
            frame_byte_q.push_back(fb);
        end
    endtask

    // Mostly well-formed frames with random content, some broken or noise
    task automatic add_random_frame();
        int          r;
        int          len;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        r     = $urandom_range(0, 99);
        etype = ($urandom_range(0, 99) < 85) ? EtherTypeIpv4 : 16'($urandom);
        ihl   = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(5, 15))
                                              : 4'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0, 1:    proto = ProtoTcp;
            2:       proto = ProtoUdp;
            default: proto = 8'($urandom);
        endcase
        if (r < 70)
            len = $urandom_range(20, 100);
        else if (r < 90)
            len = $urandom_range(1, 40);
        else if (r < 98)
            len = $urandom_range(100, 140);
        else
            len = $urandom_range(141, 250);
        add_frame(len, etype, ihl, proto, 4'($urandom), 1'($urandom), 16'($urandom),
                  $urandom_range(0, 9) == 0);
        rand_bytes += len;
        rand_frames++;
    endtask

    // Wait until the input queue is empty and every header word has arrived
    task automatic wait_drained();
        do
            @(negedge clk);
        while (frame_byte_q.size() != 0 || s_tvalid || hdr_expect_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_csum_enable(input logic en);
        @(posedge clk);
        cfg_data  <= en;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Byte driver, fed from the pending queue
    always @(posedge clk)
    begin : drive_bytes
        frame_byte_t fb;
        in_word_t    w;
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (tx_gap_left > 0)
            begin
                s_tvalid    <= 1'b0;
                tx_gap_left <= tx_gap_left - 1;
            end
            else if (frame_byte_q.size() != 0)
            begin
                fb            = frame_byte_q.pop_front();
                w             = '0;
                w.data_byte   = fb.data;
                w.seg_request = fb.seg_req;
                w.seg_mss     = fb.mss;
                s_tdata  <= w;
                s_tlast  <= fb.last;
                s_tvalid <= 1'b1;
                if (!tx_steady && $urandom_range(0, 1) == 1)
                    tx_gap_left <= idle_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result-side ready: random stalls, steady stretches, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_seq != rx_hold_seen)
            begin
                rx_hold_seen  <= rx_hold_seq;
                rx_stall_left <= RxHoldCycles;
                m_tready      <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left <= rx_stall_left - 1;
                m_tready      <= 1'b0;
            end
            else if (rx_steady || $urandom_range(0, 99) < 65)
                m_tready <= 1'b1;
            else
            begin
                rx_stall_left <= idle_len() - 1;
                m_tready      <= 1'b0;
            end
        end
    end

    // Header predictor: tracks enable writes and every accepted byte
    always @(posedge clk)
    begin : predict_headers
        offload_hdr_t hdr;
        in_word_t     w;
        logic [7:0]   flen;
        logic         hdr_ok;
        logic         is_tcp;
        logic         is_udp;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                csum_en_model = cfg_data;
            if (s_tvalid && s_tready)
            begin
                w = in_word_t'(s_tdata);
                // capture header fields by byte position
                if (frame_pos == PosEtherHi)
                    cap_ether[15:8] = w.data_byte;
                else if (frame_pos == PosEtherLo)
                    cap_ether[7:0] = w.data_byte;
                else if (frame_pos == PosIpVerLen)
                    cap_ip_len = {w.data_byte[3:0], 2'b00};
                else if (frame_pos == PosIpProto)
                    cap_proto = w.data_byte;
                if (frame_pos > PosIpVerLen && {1'b0, frame_pos} == TcpOffBase + cap_ip_len)
                    cap_tcp_len = {w.data_byte[7:4], 2'b00};
                flen = {1'b0, frame_pos} + 8'd1;
                if (frame_pos != CountMax)
                    frame_pos = frame_pos + 7'd1;

                if (s_tlast)
                begin
                    hdr    = '{default: '0};
                    hdr_ok = flen >= MinFrameBytes && cap_ether == EtherTypeIpv4
                             && cap_ip_len >= MinIpHdrBytes
                             && flen >= EthHdrBytes + cap_ip_len + MinL4HdrBytes;
                    is_tcp = cap_proto == ProtoTcp;
                    is_udp = cap_proto == ProtoUdp;
                    if (hdr_ok && w.seg_request && is_tcp)
                    begin
                        hdr.seg_type    = 1'b1;
                        hdr.seg_size    = w.seg_mss;
                        hdr.headers_len = EthHdrBytes + cap_ip_len + cap_tcp_len;
                    end
                    else if (hdr_ok && csum_en_model && (is_tcp || is_udp))
                    begin
                        hdr.needs_csum      = 1'b1;
                        hdr.cksum_begin     = 7'(EthHdrBytes + cap_ip_len);
                        hdr.cksum_field_pos = is_tcp ? TcpCsumOff : UdpCsumOff;
                    end
                    hdr_expect_q.push_back(hdr);
                    frame_pos   = '0;
                    cap_ether   = '0;
                    cap_ip_len  = '0;
                    cap_proto   = '0;
                    cap_tcp_len = '0;
                end
            end
        end
    end

    // Result checker: each word against the oldest expected header
    always @(posedge clk)
    begin : check_headers
        offload_hdr_t want;
        out_word_t    got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_word_t'(m_tdata);
            if (hdr_expect_q.size() == 0)
                report_error($sformatf("unexpected header word 0x%0h", m_tdata));
            else
            begin
                want = hdr_expect_q.pop_front();
                check_field("seg_type", 16'(got.seg_type), 16'(want.seg_type));
                check_field("seg_size", got.seg_size, want.seg_size);
                check_field("headers_len", 16'(got.headers_len), 16'(want.headers_len));
                check_field("needs_csum", 16'(got.needs_csum), 16'(want.needs_csum));
                check_field("cksum_begin", 16'(got.cksum_begin), 16'(want.cksum_begin));
                check_field("cksum_field_pos", 16'(got.cksum_field_pos),
                            16'(want.cksum_field_pos));
            end
        end
    end

    // Stimulus phases
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames with checksum offload enabled
        write_csum_enable(1'b1);
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'hFFFF, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'h0000, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd8, 1'b0, 16'h1234, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoUdp, 4'd0, 1'b1, 16'hFFFF, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd5, 8'd1, 4'd5, 1'b1, 16'h05DC, 1'b0);
        add_frame(54, 16'h86DD, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'h05DC, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd4, ProtoTcp, 4'd5, 1'b1, 16'h05DC, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd0, ProtoUdp, 4'd5, 1'b0, 16'h05DC, 1'b0);
        // length right at and just below the minimum
        add_frame(53, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'hABCD, 1'b0);
        add_frame(33, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'hABCD, 1'b0);
        add_frame(93, EtherTypeIpv4, 4'd15, ProtoTcp, 4'd15, 1'b1, 16'h0100, 1'b0);
        add_frame(94, EtherTypeIpv4, 4'd15, ProtoTcp, 4'd15, 1'b0, 16'h0100, 1'b0);
        // maximum headers, frame past the saturating count
        add_frame(134, EtherTypeIpv4, 4'd15, ProtoTcp, 4'd15, 1'b1, 16'h8000, 1'b0);
        // data offset below five
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd0, 1'b1, 16'h7FFF, 1'b0);
        add_frame(1, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'hFFFF, 1'b0);
        add_frame(13, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b1, 16'hFFFF, 1'b0);
        wait_drained();

        // Checksum offload disabled
        write_csum_enable(1'b0);
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5, 1'b0, 16'h0000, 1'b0);
        add_frame(54, EtherTypeIpv4, 4'd5, ProtoUdp, 4'd5, 1'b1, 16'hFFFF, 1'b0);
        add_frame(74, EtherTypeIpv4, 4'd10, ProtoTcp, 4'd10, 1'b1, 16'h4321, 1'b0);
        wait_drained();

        // Random frames, enable on, random idling on both sides
        write_csum_enable(1'b1);
        repeat (2) add_random_frame();
        wait_drained();

        // Long result hold-off while short frames keep coming
        tx_steady = 1'b1;
        rx_hold_seq++;
        repeat (40)
            add_frame($urandom_range(1, 3), EtherTypeIpv4, 4'd5, ProtoTcp, 4'd5,
                      1'($urandom), 16'($urandom), 1'b0);
        wait_drained();

        // Back to back on both sides, enable off
        write_csum_enable(1'b0);
        rx_steady = 1'b1;
        repeat (2) add_random_frame();
        wait_drained();

        // Bulk random traffic, enable on
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        write_csum_enable(1'b1);
        while (rand_bytes < 250 || rand_frames < 5)
            add_random_frame();
        wait_drained();

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("l4_offload_header_builder verification clean");
        else
            $display("l4_offload_header_builder verification failed");
        $finish;
    end

    // Run time limit
    initial
    begin
        #10_000_000;
        $display("l4_offload_header_builder verification failed");
        $finish;
    end

endmodule
